// File: rtl/scs_pkg.sv
package scs_pkg;

    localparam int ANGLE_W = 42;
    localparam int SERIES_FRAC = 58;
    localparam int TERM_W = 64;

    localparam logic signed [ANGLE_W-1:0] PI_Q32 = 42'sd13493037705;
    localparam logic signed [ANGLE_W-1:0] TWO_PI_Q32 = 42'sd26986075409;
    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q32 = 42'sd6746518852;
    localparam logic signed [ANGLE_W-1:0] REDUCE_BIAS = TWO_PI_Q32 - PI_Q32 - 42'sd1;

    localparam logic [3:0] TERM_COUNT_RESET = 4'd7;

    typedef struct packed {
        logic              neg;
        logic [TERM_W-1:0] x2;
        logic [TERM_W-1:0] sum;
    } t_carry;

endpackage

// File: rtl/scs_front.sv
module scs_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic                  i_kind,
    input  logic signed [31:0]    i_angle,
    output logic                  o_valid,
    output logic [63:0]           o_term,
    output scs_pkg::t_carry       o_carry
);

    localparam int STAGES = 10;
    localparam int STEPS = 5;
    localparam int ZW = scs_pkg::ANGLE_W - 1;
    localparam logic [ZW-1:0] TWO_PI_Z = ZW'(scs_pkg::TWO_PI_Q32);

    logic [STAGES-1:0]                  r_vld;
    logic signed [scs_pkg::ANGLE_W-1:0] r_x;
    logic signed [scs_pkg::ANGLE_W-1:0] n_ax;
    logic signed [scs_pkg::ANGLE_W-1:0] n_x;
    logic signed [scs_pkg::ANGLE_W-1:0] n_z;
    logic                               r_s [0:STEPS];
    logic [ZW-1:0]                      r_z [0:STEPS];
    logic signed [scs_pkg::ANGLE_W-1:0] n_y;
    logic signed [scs_pkg::ANGLE_W-1:0] r_y;
    logic                               r_ys;
    logic                               r_neg;
    logic [33:0]                        r_mag;
    logic                               r_out_neg;
    logic [33:0]                        r_out_mag;
    logic [67:0]                        n_sq;
    logic [63:0]                        r_x2;

    always_comb begin
        n_ax = $signed({{2{i_angle[31]}}, i_angle, 8'd0});
        n_x  = i_kind ? scs_pkg::HALF_PI_Q32 - n_ax : n_ax;
        n_z  = r_x[scs_pkg::ANGLE_W-1] ? scs_pkg::REDUCE_BIAS - r_x
                                       : r_x + scs_pkg::REDUCE_BIAS;
        n_y  = $signed({1'b0, r_z[STEPS]}) - scs_pkg::REDUCE_BIAS;
        n_sq = 68'(r_mag) * 68'(r_mag) + 68'd32;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_s[0] <= r_x[scs_pkg::ANGLE_W-1];
            r_z[0] <= n_z[ZW-1:0];
            for (int j = 1; j <= STEPS; j++) begin
                r_s[j] <= r_s[j-1];
                r_z[j] <= (r_z[j-1] >= (TWO_PI_Z << (STEPS - j)))
                          ? r_z[j-1] - (TWO_PI_Z << (STEPS - j)) : r_z[j-1];
            end
            r_y       <= n_y;
            r_ys      <= r_s[STEPS];
            r_neg     <= r_ys ? (!r_y[scs_pkg::ANGLE_W-1] && (r_y != '0))
                              : r_y[scs_pkg::ANGLE_W-1];
            r_mag     <= r_y[scs_pkg::ANGLE_W-1] ? 34'(-r_y) : 34'(r_y);
            r_out_neg <= r_neg;
            r_out_mag <= r_mag;
            r_x2      <= 64'(n_sq[67:6]);
        end
    end

    always_comb begin
        o_valid       = r_vld[STAGES-1];
        o_term        = {4'd0, r_out_mag, 26'd0};
        o_carry.neg   = r_out_neg;
        o_carry.x2    = r_x2;
        o_carry.sum   = {4'd0, r_out_mag, 26'd0};
    end

endmodule

// File: rtl/scs_div_digit.sv
module scs_div_digit #(
    parameter int D = 6,
    localparam int RW = $clog2(D)
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [RW-1:0] i_rem,
    input  logic [63:0]   i_word,
    output logic [RW-1:0] o_rem,
    output logic [63:0]   o_word
);

    localparam int NW = RW + 16;
    localparam int QW = NW - RW + 1;
    localparam logic [QW-1:0] RECIP = QW'((1 << NW) / D);
    localparam logic [NW-1:0] DIVISOR = NW'(D);

    logic [NW-1:0]    n_num;
    logic [NW-1:0]    r_num;
    logic [NW+QW-1:0] r_prod;
    logic [47:0]      r_low;
    logic [15:0]      n_q0;
    logic [NW-1:0]    n_r;
    logic             n_fix;
    logic [RW-1:0]    r_rem;
    logic [63:0]      r_word;

    always_comb begin
        n_num = {i_rem, i_word[63:48]};
        n_q0  = r_prod[NW+15:NW];
        n_r   = r_num - NW'(n_q0) * DIVISOR;
        n_fix = n_r >= DIVISOR;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= n_num;
            r_prod <= n_num * RECIP;
            r_low  <= i_word[47:0];
            r_rem  <= n_fix ? RW'(n_r - DIVISOR) : RW'(n_r);
            r_word <= {r_low, n_fix ? n_q0 + 16'd1 : n_q0};
        end
    end

    assign o_rem  = r_rem;
    assign o_word = r_word;

endmodule

// File: rtl/scs_cell.sv
module scs_cell #(
    parameter int K = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [63:0]     i_term,
    input  scs_pkg::t_carry i_carry,
    input  logic [3:0]      i_count,
    output logic            o_valid,
    output logic [63:0]     o_term,
    output scs_pkg::t_carry o_carry
);

    localparam int D = (2 * K) * (2 * K + 1);
    localparam int RW = $clog2(D);
    localparam int DIGITS = 4;
    localparam int STAGES = 5 + 2 * DIGITS;
    localparam logic [63:0] HALF_D = 64'(D / 2);
    localparam logic [64:0] ROUND_HALF = 65'd1 << (scs_pkg::SERIES_FRAC - 1);
    localparam logic [3:0] INDEX = 4'(K);
    localparam bit SUBTRACT = (K % 2) == 1;

    logic [STAGES-1:0] r_vld;
    scs_pkg::t_carry   r_cd [0:STAGES-1];
    logic [63:0]       r_ll;
    logic [63:0]       r_lh;
    logic [63:0]       r_hl;
    logic [63:0]       r_hh;
    logic [64:0]       r_mid;
    logic [64:0]       r_lo;
    logic [63:0]       r_hh2;
    logic [127:0]      n_full;
    logic [63:0]       r_q;
    logic [63:0]       r_num;
    logic [RW-1:0]     w_rem [0:DIGITS];
    logic [63:0]       w_word [0:DIGITS];
    logic [63:0]       n_sum;
    logic [63:0]       r_term;

    always_comb begin
        n_full = {r_hh2, 64'd0} + {31'd0, r_mid, 32'd0} + {63'd0, r_lo};
        if (INDEX < i_count) begin
            n_sum = SUBTRACT ? r_cd[STAGES-2].sum - w_word[DIGITS]
                             : r_cd[STAGES-2].sum + w_word[DIGITS];
        end else begin
            n_sum = r_cd[STAGES-2].sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cd[0] <= i_carry;
            for (int s = 1; s < STAGES - 1; s++) begin
                r_cd[s] <= r_cd[s-1];
            end
            r_cd[STAGES-1].neg <= r_cd[STAGES-2].neg;
            r_cd[STAGES-1].x2  <= r_cd[STAGES-2].x2;
            r_cd[STAGES-1].sum <= n_sum;
            r_term <= w_word[DIGITS];

            r_ll  <= i_term[31:0]  * i_carry.x2[31:0];
            r_lh  <= i_term[31:0]  * i_carry.x2[63:32];
            r_hl  <= i_term[63:32] * i_carry.x2[31:0];
            r_hh  <= i_term[63:32] * i_carry.x2[63:32];
            r_mid <= {1'b0, r_lh} + {1'b0, r_hl};
            r_lo  <= {1'b0, r_ll} + ROUND_HALF;
            r_hh2 <= r_hh;
            r_q   <= n_full[121:58];
            r_num <= r_q + HALF_D;
        end
    end

    assign w_rem[0]  = '0;
    assign w_word[0] = r_num;

    for (genvar g = 0; g < DIGITS; g++) begin : g_digit
        scs_div_digit #(
            .D(D)
        ) u_digit (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_rem  (w_rem[g]),
            .i_word (w_word[g]),
            .o_rem  (w_rem[g+1]),
            .o_word (w_word[g+1])
        );
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_term  = r_term;
    assign o_carry = r_cd[STAGES-1];

endmodule

// File: rtl/sine_cosine_series.sv
// Sine or cosine of a fixed-point angle by a truncated Maclaurin series.
//
// Input channel: i_in_valid / o_in_ready carry i_kind (0 sine, 1 cosine) and
// i_angle, radians in two's complement with 24 fraction bits.
// Output channel: o_out_valid / i_out_ready carry o_value, two's complement
// with 30 fraction bits, one result per item, in order.
// Config channel: i_cfg_valid / o_cfg_ready write i_cfg_term_count, the
// number of odd series terms summed (0 acts as 1, above MAX_TERMS as
// MAX_TERMS). Write it only while no item is in flight; o_cfg_ready is
// always high.
//
// Pipeline: 10 reduction stages, 13 stages per series cell (split 64x64
// multiply, then division by (2k)(2k+1) in four 16-bit digits), 2 rounding
// stages and the output register. Throughput is one item per cycle while
// o_in_ready is high.
// When the receiver stalls, one more result moves into a skid register and
// then o_in_ready drops until the output is taken.
// Reset clears all valid bits and sets the term count to 7, or to MAX_TERMS if smaller.
module sine_cosine_series #(
    parameter int MAX_TERMS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_kind,
    input  logic signed [31:0] i_angle,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_term_count
);

    localparam int NCELL = MAX_TERMS - 1;
    localparam logic [3:0] TERMS_MAX = 4'(MAX_TERMS);
    localparam logic [3:0] TERMS_RESET =
        (scs_pkg::TERM_COUNT_RESET > TERMS_MAX) ? TERMS_MAX : scs_pkg::TERM_COUNT_RESET;
    localparam logic [63:0] ROUND_OUT = 64'd1 << 27;
    localparam logic [35:0] POS_LIMIT = 36'h0_7FFF_FFFF;
    localparam logic [35:0] NEG_LIMIT = 36'h0_8000_0000;

    logic            en;
    logic            n_take;
    logic [3:0]      r_terms;
    logic [3:0]      n_terms;
    logic            w_vld [0:NCELL];
    logic [63:0]     w_term [0:NCELL];
    scs_pkg::t_carry w_carry [0:NCELL];
    logic            r_fa_v;
    logic            r_fa_neg;
    logic [63:0]     r_fa_mag;
    logic [63:0]     n_rnd;
    logic [35:0]     n_r;
    logic [31:0]     n_value;
    logic            r_fb_v;
    logic [31:0]     r_fb_value;
    logic            r_out_valid;
    logic [31:0]     r_out_value;
    logic            r_skid_valid;
    logic [31:0]     r_skid_value;

    assign en          = !r_skid_valid;
    assign n_take      = r_out_valid && i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_value     = $signed(r_out_value);

    always_comb begin
        if (i_cfg_term_count == 4'd0) begin
            n_terms = 4'd1;
        end else if (i_cfg_term_count > TERMS_MAX) begin
            n_terms = TERMS_MAX;
        end else begin
            n_terms = i_cfg_term_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_terms <= TERMS_RESET;
        end else if (i_cfg_valid) begin
            r_terms <= n_terms;
        end
    end

    scs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_kind  (i_kind),
        .i_angle (i_angle),
        .o_valid (w_vld[0]),
        .o_term  (w_term[0]),
        .o_carry (w_carry[0])
    );

    for (genvar c = 0; c < NCELL; c++) begin : g_cell
        scs_cell #(
            .K(c + 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_vld[c]),
            .i_term  (w_term[c]),
            .i_carry (w_carry[c]),
            .i_count (r_terms),
            .o_valid (w_vld[c+1]),
            .o_term  (w_term[c+1]),
            .o_carry (w_carry[c+1])
        );
    end

    always_comb begin
        n_rnd = r_fa_mag + ROUND_OUT;
        n_r   = n_rnd[63:28];
        if (r_fa_neg) begin
            n_value = (n_r > NEG_LIMIT) ? 32'h8000_0000 : -n_r[31:0];
        end else begin
            n_value = (n_r > POS_LIMIT) ? 32'h7FFF_FFFF : n_r[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fa_v <= 1'b0;
            r_fb_v <= 1'b0;
        end else if (en) begin
            r_fa_v <= w_vld[NCELL];
            r_fb_v <= r_fa_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fa_neg   <= w_carry[NCELL].neg ^ w_carry[NCELL].sum[63];
            r_fa_mag   <= w_carry[NCELL].sum[63] ? -w_carry[NCELL].sum : w_carry[NCELL].sum;
            r_fb_value <= n_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (n_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_fb_v) begin
            if (r_out_valid && !i_out_ready) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (n_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (n_take) begin
                r_out_value <= r_skid_value;
            end
        end else if (r_fb_v) begin
            if (r_out_valid && !i_out_ready) begin
                r_skid_value <= r_fb_value;
            end else begin
                r_out_value <= r_fb_value;
            end
        end
    end

endmodule

// File: rtl/scs_checker.sv
module scs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_value
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_value))
        else $error("stalled result changed or dropped");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("reset left output valid or input blocked");

    // input blocks only after a stalled output
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(o_out_valid && !i_out_ready))
        else $error("input ready dropped without output stall");

    a_ready_stay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready && o_out_valid && !i_out_ready |=> !o_in_ready)
        else $error("input ready rose while output still stalled");

endmodule

bind sine_cosine_series scs_checker u_scs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_value     (o_value)
);
